/* src/vcc_pkg.sv */
// Package: shared types, codes and reset constants of the vending credit controller.
`default_nettype none

package vcc_pkg;

    // Datapath widths
    localparam int CREDIT_W = 12;
    localparam int COIN_W   = 8;
    localparam int SLOT_W   = 2;
    localparam int STOCK_W  = 4;

    // Number of price registers (slots that can carry a price)
    localparam int PRICE_SLOTS = 3;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

    // Slot code meaning no slot chosen yet
    localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PRICE_0 = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRICE_1 = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PRICE_2 = 2'd2;

    // Price reset values
    localparam logic [CREDIT_W-1:0] PRICE_0_RST = 12'd10;
    localparam logic [CREDIT_W-1:0] PRICE_1_RST = 12'd20;
    localparam logic [CREDIT_W-1:0] PRICE_2_RST = 12'd30;

    // Event codes
    localparam logic [1:0] ACT_COIN     = 2'd0;
    localparam logic [1:0] ACT_EJECT    = 2'd1;
    localparam logic [1:0] ACT_SELECT   = 2'd2;
    localparam logic [1:0] ACT_DISPENSE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_ALLOWED = 2'd1;
    localparam logic [1:0] ST_NO_STOCK    = 2'd2;
    localparam logic [1:0] ST_SHORT       = 2'd3;

    // Controller mode
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_CREDIT   = 2'd1,
        MODE_DISPENSE = 2'd2
    } t_mode;

    typedef logic [PRICE_SLOTS-1:0][CREDIT_W-1:0] t_prices;

    // Input transaction
    typedef struct packed {
        logic [1:0]        action;
        logic [COIN_W-1:0] coin_value;
        logic [SLOT_W-1:0] product_id;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [1:0]          status;
        logic [CREDIT_W-1:0] refund_amount;
        logic [CREDIT_W-1:0] shortfall;
        logic                dispensed;
        logic [SLOT_W-1:0]   dispensed_slot;
        logic [1:0]          mode_after;
        logic [CREDIT_W-1:0] credit_after;
    } t_out_item;

endpackage

`default_nettype wire

/* src/vcc_cfg.sv */
// Price register file written through the configuration port.
`default_nettype none

module vcc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [vcc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [vcc_pkg::CREDIT_W-1:0]    i_cfg_wdata,
    output vcc_pkg::t_prices                     o_prices
);

    vcc_pkg::t_prices r_prices;

    // Price registers, back to defaults on reset; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prices[0] <= vcc_pkg::PRICE_0_RST;
            r_prices[1] <= vcc_pkg::PRICE_1_RST;
            r_prices[2] <= vcc_pkg::PRICE_2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                vcc_pkg::REG_PRICE_0: r_prices[0] <= i_cfg_wdata;
                vcc_pkg::REG_PRICE_1: r_prices[1] <= i_cfg_wdata;
                vcc_pkg::REG_PRICE_2: r_prices[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_prices = r_prices;

endmodule

`default_nettype wire

/* src/vcc_core.sv */
// Controller state (mode, credit, chosen slot, stock) and the per-event decision logic.
`default_nettype none

module vcc_core #(
    parameter int INITIAL_STOCK = 10,
    parameter int SLOT_COUNT    = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire vcc_pkg::t_in_item i_item,
    input  wire vcc_pkg::t_prices  i_prices,
    output vcc_pkg::t_out_item     o_result
);

    vcc_pkg::t_mode                      r_mode, n_mode;
    logic [vcc_pkg::CREDIT_W-1:0]        r_credit, n_credit;
    logic [vcc_pkg::SLOT_W-1:0]          r_chosen, n_chosen;
    logic [vcc_pkg::STOCK_W-1:0]         r_stock [SLOT_COUNT];

    logic [vcc_pkg::CREDIT_W:0]          w_sum;
    logic [vcc_pkg::CREDIT_W-1:0]        w_sat_credit;
    logic                                w_pid_ok;
    logic [vcc_pkg::STOCK_W-1:0]         w_pid_stock;
    logic [vcc_pkg::CREDIT_W-1:0]        w_price;
    logic                                w_chosen_ok;
    logic [vcc_pkg::STOCK_W-1:0]         w_chosen_stock;
    logic                                w_sel_good;
    logic                                w_enough;
    logic                                w_disp_good;
    logic                                w_take;

    // Saturating credit add
    assign w_sum        = {1'b0, r_credit} + {{(vcc_pkg::CREDIT_W + 1 - vcc_pkg::COIN_W){1'b0}},
                                              i_item.coin_value};
    assign w_sat_credit = w_sum[vcc_pkg::CREDIT_W] ? vcc_pkg::CREDIT_MAX
                                                   : w_sum[vcc_pkg::CREDIT_W-1:0];

    // Stock lookup for the requested and the chosen slot
    always_comb begin
        w_pid_ok       = 1'b0;
        w_pid_stock    = '0;
        w_chosen_ok    = 1'b0;
        w_chosen_stock = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i_item.product_id == vcc_pkg::SLOT_W'(i)) begin
                w_pid_ok    = 1'b1;
                w_pid_stock = r_stock[i];
            end
            if (r_chosen == vcc_pkg::SLOT_W'(i)) begin
                w_chosen_ok    = 1'b1;
                w_chosen_stock = r_stock[i];
            end
        end
    end

    // Price of the requested slot
    always_comb begin
        case (i_item.product_id)
            vcc_pkg::REG_PRICE_0: w_price = i_prices[0];
            vcc_pkg::REG_PRICE_1: w_price = i_prices[1];
            vcc_pkg::REG_PRICE_2: w_price = i_prices[2];
            default:              w_price = '0;
        endcase
    end

    assign w_sel_good  = w_pid_ok && (w_pid_stock != '0);
    assign w_enough    = r_credit >= w_price;
    assign w_disp_good = w_chosen_ok && (w_chosen_stock != '0);

    // Next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            vcc_pkg::MODE_CREDIT: begin
                if (i_item.action == vcc_pkg::ACT_EJECT) begin
                    n_mode = vcc_pkg::MODE_IDLE;
                end else if (i_item.action == vcc_pkg::ACT_SELECT) begin
                    n_mode = (w_sel_good && w_enough) ? vcc_pkg::MODE_DISPENSE
                                                      : vcc_pkg::MODE_IDLE;
                end
            end
            vcc_pkg::MODE_DISPENSE: begin
                if (i_item.action == vcc_pkg::ACT_DISPENSE) begin
                    n_mode = vcc_pkg::MODE_IDLE;
                end
            end
            default: begin
                // idle, and the unused code treated as idle
                n_mode = (i_item.action == vcc_pkg::ACT_COIN) ? vcc_pkg::MODE_CREDIT
                                                               : vcc_pkg::MODE_IDLE;
            end
        endcase
    end

    // Result fields and next credit / chosen slot / stock take
    always_comb begin
        o_result                = '0;
        o_result.status         = vcc_pkg::ST_NOT_ALLOWED;
        n_credit                = r_credit;
        n_chosen                = r_chosen;
        w_take                  = 1'b0;
        case (r_mode)
            vcc_pkg::MODE_CREDIT: begin
                case (i_item.action)
                    vcc_pkg::ACT_COIN: begin
                        n_credit        = w_sat_credit;
                        o_result.status = vcc_pkg::ST_OK;
                    end
                    vcc_pkg::ACT_EJECT: begin
                        o_result.refund_amount = r_credit;
                        n_credit               = '0;
                        o_result.status        = vcc_pkg::ST_OK;
                    end
                    vcc_pkg::ACT_SELECT: begin
                        if (!w_sel_good) begin
                            o_result.status        = vcc_pkg::ST_NO_STOCK;
                            o_result.refund_amount = r_credit;
                            n_credit               = '0;
                        end else begin
                            n_chosen = i_item.product_id;
                            if (w_enough) begin
                                o_result.refund_amount = r_credit - w_price;
                                n_credit               = w_price;
                                o_result.status        = vcc_pkg::ST_OK;
                            end else begin
                                o_result.status        = vcc_pkg::ST_SHORT;
                                o_result.shortfall     = w_price - r_credit;
                                o_result.refund_amount = r_credit;
                                n_credit               = '0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            vcc_pkg::MODE_DISPENSE: begin
                if (i_item.action == vcc_pkg::ACT_DISPENSE) begin
                    n_credit = '0;
                    if (w_disp_good) begin
                        w_take                  = 1'b1;
                        o_result.dispensed      = 1'b1;
                        o_result.dispensed_slot = r_chosen;
                        o_result.status         = vcc_pkg::ST_OK;
                    end else begin
                        o_result.status        = vcc_pkg::ST_NO_STOCK;
                        o_result.refund_amount = r_credit;
                    end
                end
            end
            default: begin
                if (i_item.action == vcc_pkg::ACT_COIN) begin
                    n_credit        = w_sat_credit;
                    o_result.status = vcc_pkg::ST_OK;
                end
            end
        endcase
        o_result.mode_after   = n_mode;
        o_result.credit_after = n_credit;
    end

    // State registers, updated once per processed event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= vcc_pkg::MODE_IDLE;
            r_credit <= '0;
            r_chosen <= vcc_pkg::SLOT_NONE;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_credit <= n_credit;
            r_chosen <= n_chosen;
        end
    end

    // Stock counters, one per slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_stock[i] <= vcc_pkg::STOCK_W'(INITIAL_STOCK);
            end
        end else if (i_fire && w_take) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (r_chosen == vcc_pkg::SLOT_W'(i)) begin
                    r_stock[i] <= r_stock[i] - vcc_pkg::STOCK_W'(1);
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/vending_credit_controller.sv */
// Vending credit controller: input register, decision core and result register.
// Each transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless the output stalls; the core state is
// updated in the same cycle the result register loads; back-to-back events see it.
// Reset (synchronous, active low): idle mode, zero credit, no slot chosen,
// stock at INITIAL_STOCK in every slot, prices back to 10/20/30, pipeline empty.
`default_nettype none

module vending_credit_controller #(
    parameter int INITIAL_STOCK = 10,
    parameter int SLOT_COUNT    = 3
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [vcc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [vcc_pkg::CREDIT_W-1:0]    i_cfg_wdata,
    // event input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire vcc_pkg::t_in_item               i_in_data,
    // result output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output vcc_pkg::t_out_item                   o_out_data
);

    vcc_pkg::t_prices    w_prices;
    vcc_pkg::t_in_item   r_in;
    logic                r_in_valid;
    vcc_pkg::t_out_item  r_out;
    logic                r_out_valid;
    vcc_pkg::t_out_item  w_result;
    logic                w_fire;

    vcc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_prices    (w_prices)
    );

    vcc_core #(
        .INITIAL_STOCK (INITIAL_STOCK),
        .SLOT_COUNT    (SLOT_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_prices (w_prices),
        .o_result (w_result)
    );

    // Process the held event when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* verif/tb_vending_credit_controller.sv */
// Testbench: directed and random event streams for the vending credit controller.
`default_nettype none

module tb_vending_credit_controller;

    localparam int SLOTS      = 3;
    localparam int FULL_STOCK = 10;
    localparam int LIMIT_TIME = 10_000_000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [vcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [vcc_pkg::CREDIT_W-1:0]   i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_stall;
    vcc_pkg::t_in_item              i_in_data;
    logic                           o_out_valid;
    logic                           i_out_stall;
    vcc_pkg::t_out_item             o_out_data;

    vending_credit_controller #(
        .INITIAL_STOCK (FULL_STOCK),
        .SLOT_COUNT    (SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow controller state
    vcc_pkg::t_mode               m_mode;
    logic [vcc_pkg::CREDIT_W-1:0] m_credit;
    logic [vcc_pkg::SLOT_W-1:0]   m_chosen;
    logic [vcc_pkg::STOCK_W-1:0]  m_stock [SLOTS];
    logic [vcc_pkg::CREDIT_W-1:0] m_price [vcc_pkg::PRICE_SLOTS];

    vcc_pkg::t_out_item outcome_q[$];

    int n_fail;
    int n_events;
    int n_checked;
    int n_released;
    int status_hist[4];
    bit steady_src;
    bit steady_sink;

    // Outcome of one event; advances the shadow state
    function automatic vcc_pkg::t_out_item vend_outcome(input vcc_pkg::t_in_item ev);
        vcc_pkg::t_out_item           r;
        logic [vcc_pkg::CREDIT_W:0]   sum;
        logic [vcc_pkg::CREDIT_W-1:0] cost;
        logic                         slot_ok;
        r        = '0;
        r.status = vcc_pkg::ST_NOT_ALLOWED;
        sum      = (vcc_pkg::CREDIT_W + 1)'(m_credit) + (vcc_pkg::CREDIT_W + 1)'(ev.coin_value);
        case (m_mode)
            vcc_pkg::MODE_CREDIT: begin
                if (ev.action == vcc_pkg::ACT_COIN) begin
                    m_credit = sum[vcc_pkg::CREDIT_W] ? vcc_pkg::CREDIT_MAX
                                                      : sum[vcc_pkg::CREDIT_W-1:0];
                    r.status = vcc_pkg::ST_OK;
                end else if (ev.action == vcc_pkg::ACT_EJECT) begin
                    r.refund_amount = m_credit;
                    m_credit        = '0;
                    m_mode          = vcc_pkg::MODE_IDLE;
                    r.status        = vcc_pkg::ST_OK;
                end else if (ev.action == vcc_pkg::ACT_SELECT) begin
                    slot_ok = 1'b0;
                    if (ev.product_id < SLOTS)
                        slot_ok = (m_stock[ev.product_id] != 0);
                    if (!slot_ok) begin
                        // bad slot or sold out: full refund
                        r.status        = vcc_pkg::ST_NO_STOCK;
                        r.refund_amount = m_credit;
                        m_credit        = '0;
                        m_mode          = vcc_pkg::MODE_IDLE;
                    end else begin
                        cost     = m_price[ev.product_id];
                        m_chosen = ev.product_id;
                        if (m_credit >= cost) begin
                            r.refund_amount = m_credit - cost;
                            m_credit        = cost;
                            m_mode          = vcc_pkg::MODE_DISPENSE;
                            r.status        = vcc_pkg::ST_OK;
                        end else begin
                            r.status        = vcc_pkg::ST_SHORT;
                            r.shortfall     = cost - m_credit;
                            r.refund_amount = m_credit;
                            m_credit        = '0;
                            m_mode          = vcc_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            vcc_pkg::MODE_DISPENSE: begin
                if (ev.action == vcc_pkg::ACT_DISPENSE) begin
                    slot_ok = 1'b0;
                    if (m_chosen < SLOTS)
                        slot_ok = (m_stock[m_chosen] != 0);
                    if (slot_ok) begin
                        m_stock[m_chosen] = m_stock[m_chosen] - vcc_pkg::STOCK_W'(1);
                        m_credit          = '0;
                        r.dispensed       = 1'b1;
                        r.dispensed_slot  = m_chosen;
                        r.status          = vcc_pkg::ST_OK;
                    end else begin
                        r.status        = vcc_pkg::ST_NO_STOCK;
                        r.refund_amount = m_credit;
                        m_credit        = '0;
                    end
                    m_mode = vcc_pkg::MODE_IDLE;
                end
            end
            default: begin
                if (ev.action == vcc_pkg::ACT_COIN) begin
                    m_credit = sum[vcc_pkg::CREDIT_W] ? vcc_pkg::CREDIT_MAX
                                                      : sum[vcc_pkg::CREDIT_W-1:0];
                    m_mode   = vcc_pkg::MODE_CREDIT;
                    r.status = vcc_pkg::ST_OK;
                end
            end
        endcase
        r.mode_after   = m_mode;
        r.credit_after = m_credit;
        return r;
    endfunction

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic vcc_pkg::t_in_item make_event(input logic [1:0] act,
                                                     input logic [vcc_pkg::COIN_W-1:0] coin,
                                                     input logic [vcc_pkg::SLOT_W-1:0] pid);
        vcc_pkg::t_in_item ev;
        ev.action     = act;
        ev.coin_value = coin;
        ev.product_id = pid;
        return ev;
    endfunction

    // Mode-aware event picker; p_leave sets how often credit mode is left
    function automatic vcc_pkg::t_in_item pick_event(input int p_leave);
        vcc_pkg::t_in_item ev;
        int                r;
        r = $urandom_range(0, 9);
        if (r == 0)
            ev.coin_value = '0;
        else if (r == 1)
            ev.coin_value = '1;
        else
            ev.coin_value = vcc_pkg::COIN_W'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            ev.product_id = vcc_pkg::SLOT_NONE;
        else
            ev.product_id = vcc_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(0, 99) < 12) begin
            ev.action = 2'($urandom_range(0, 3));
        end else begin
            case (m_mode)
                vcc_pkg::MODE_CREDIT: begin
                    r = $urandom_range(0, 99);
                    if (r >= p_leave)
                        ev.action = vcc_pkg::ACT_COIN;
                    else if (r % 3 == 0)
                        ev.action = vcc_pkg::ACT_EJECT;
                    else
                        ev.action = vcc_pkg::ACT_SELECT;
                end
                vcc_pkg::MODE_DISPENSE: ev.action = vcc_pkg::ACT_DISPENSE;
                default:                ev.action = vcc_pkg::ACT_COIN;
            endcase
        end
        return ev;
    endfunction

    // Send one transaction; entered and left at a falling edge
    task automatic send_event(input vcc_pkg::t_in_item ev);
        vcc_pkg::t_out_item want;
        int                 gap;
        gap = 0;
        if (!steady_src && $urandom_range(0, 99) >= 55)
            gap = idle_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = ev;
        do
            @(posedge i_clk);
        while (o_in_stall);
        want = vend_outcome(ev);
        outcome_q.insert(outcome_q.size(), want);
        n_events++;
        status_hist[want.status]++;
        if (want.dispensed)
            n_released++;
        @(negedge i_clk);
    endtask

    // Drain all outstanding results before touching registers
    task automatic settle();
        i_in_valid = 1'b0;
        while (outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [vcc_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [vcc_pkg::CREDIT_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        m_price[idx] = val;
    endtask

    task automatic set_prices(input logic [vcc_pkg::CREDIT_W-1:0] p0, p1, p2);
        settle();
        write_reg(vcc_pkg::REG_PRICE_0, p0);
        write_reg(vcc_pkg::REG_PRICE_1, p1);
        write_reg(vcc_pkg::REG_PRICE_2, p2);
    endtask

    task automatic run_mix(input int count, input int p_leave);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                steady_src  = ($urandom_range(0, 3) == 0);
                steady_sink = ($urandom_range(0, 3) == 0);
            end
            send_event(pick_event(p_leave));
        end
        steady_src  = 1'b0;
        steady_sink = 1'b0;
    endtask

    // Directed: anything but a coin is refused while idle
    task automatic test_idle_rejections();
        send_event(make_event(vcc_pkg::ACT_EJECT, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_DISPENSE, 8'd0, 2'd1));
    endtask

    // Directed: zero coin still enters credit mode; invalid slot refunds
    task automatic test_zero_coin_and_bad_slot();
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, vcc_pkg::SLOT_NONE));
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd200, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, vcc_pkg::SLOT_NONE));
    endtask

    // Directed: purchase with change, lockout while dispensing, exact price
    task automatic test_purchase_and_lockout();
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd255, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd7, 2'd0));
        send_event(make_event(vcc_pkg::ACT_EJECT, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd1));
        send_event(make_event(vcc_pkg::ACT_DISPENSE, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd20, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd1));
        send_event(make_event(vcc_pkg::ACT_DISPENSE, 8'd0, 2'd1));
    endtask

    // Directed: not enough credit, then eject of alternating-bit coins
    task automatic test_shortfall_and_eject();
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd5, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd2));
        send_event(make_event(vcc_pkg::ACT_COIN, 8'haa, 2'd0));
        send_event(make_event(vcc_pkg::ACT_COIN, 8'h55, 2'd0));
        send_event(make_event(vcc_pkg::ACT_EJECT, 8'd0, 2'd0));
    endtask

    // Directed: free item and the highest possible price
    task automatic test_price_extremes();
        set_prices('0, vcc_pkg::CREDIT_MAX, 12'h555);
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd1, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd1));
        send_event(make_event(vcc_pkg::ACT_COIN, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_SELECT, 8'd0, 2'd0));
        send_event(make_event(vcc_pkg::ACT_DISPENSE, 8'd0, 2'd0));
    endtask

    // Random: low prices, frequent purchases drain the stock
    task automatic test_cheap_prices();
        set_prices(vcc_pkg::CREDIT_W'($urandom_range(0, 50)),
                   vcc_pkg::CREDIT_W'($urandom_range(0, 50)),
                   vcc_pkg::CREDIT_W'($urandom_range(0, 50)));
        run_mix(200, 25);
    endtask

    // Random: every item costs nothing
    task automatic test_free_prices();
        set_prices('0, '0, '0);
        run_mix(200, 25);
    endtask

    // Random: long coin runs against top prices, credit pinned at the ceiling
    task automatic test_credit_saturation();
        set_prices(vcc_pkg::CREDIT_MAX, vcc_pkg::CREDIT_MAX, vcc_pkg::CREDIT_MAX);
        run_mix(300, 3);
    endtask

    // Random: prices 0 and 2 anywhere in range, price 1 up to 300
    task automatic test_random_prices();
        for (int k = 0; k < 2; k++) begin
            set_prices(vcc_pkg::CREDIT_W'($urandom_range(0, 4095)),
                       vcc_pkg::CREDIT_W'($urandom_range(0, 300)),
                       vcc_pkg::CREDIT_W'($urandom_range(0, 4095)));
            run_mix(275, 10 + 10 * k);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // Result side backpressure
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else if (steady_sink || $urandom_range(0, 99) < 70) begin
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = 1'b1;
            stall_left  = idle_len() - 1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        vcc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcome_q.size() == 0) begin
                $error("result transaction with no outcome pending");
                n_fail++;
            end else begin
                want = outcome_q.pop_front();
                n_checked++;
                check_field("status", want.status, o_out_data.status);
                check_field("refund_amount", want.refund_amount, o_out_data.refund_amount);
                check_field("shortfall", want.shortfall, o_out_data.shortfall);
                check_field("dispensed", want.dispensed, o_out_data.dispensed);
                check_field("dispensed_slot", want.dispensed_slot, o_out_data.dispensed_slot);
                check_field("mode_after", want.mode_after, o_out_data.mode_after);
                check_field("credit_after", want.credit_after, o_out_data.credit_after);
            end
        end
    end

    initial begin
        #LIMIT_TIME;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        steady_src  = 1'b0;
        steady_sink = 1'b0;
        n_fail      = 0;
        n_events    = 0;
        n_checked   = 0;
        n_released  = 0;
        status_hist = '{default: 0};

        // shadow reset
        m_mode     = vcc_pkg::MODE_IDLE;
        m_credit   = '0;
        m_chosen   = vcc_pkg::SLOT_NONE;
        m_price[0] = vcc_pkg::PRICE_0_RST;
        m_price[1] = vcc_pkg::PRICE_1_RST;
        m_price[2] = vcc_pkg::PRICE_2_RST;
        for (int s = 0; s < SLOTS; s++)
            m_stock[s] = vcc_pkg::STOCK_W'(FULL_STOCK);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_rejections();
        test_zero_coin_and_bad_slot();
        test_purchase_and_lockout();
        test_shortfall_and_eject();
        test_price_extremes();
        test_cheap_prices();
        test_free_prices();
        test_credit_saturation();
        test_random_prices();

        // drain and let the pipeline go quiet
        i_in_valid = 1'b0;
        while (outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d events across seven price settings: %0d accepted, %0d refused in mode,",
                 n_events, status_hist[vcc_pkg::ST_OK], status_hist[vcc_pkg::ST_NOT_ALLOWED]);
        $display("%0d out of stock, %0d short of credit; %0d results checked, %0d items released.",
                 status_hist[vcc_pkg::ST_NO_STOCK], status_hist[vcc_pkg::ST_SHORT], n_checked,
                 n_released);
        if (n_fail == 0 && outcome_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* vending_credit_controller.f */
src/vcc_pkg.sv
src/vcc_cfg.sv
src/vcc_core.sv
src/vending_credit_controller.sv
verif/tb_vending_credit_controller.sv
